@@ rtl/adcv_pkg.sv @@
// adcv_pkg: shared types, constants and tables for the averaging voltmeter
// no dependencies; imported by adc_average_voltmeter_display and its testbench

package adcv_pkg;

  // field widths
  localparam int SAMPLE_W = 10;
  localparam int BCD_W    = 6;
  localparam int SEG_W    = 7;

  // scaling to tenths of a volt: v = (avg * 33 + 511) / 1023
  localparam int VOLT_SCALE = 33;
  localparam int VOLT_ROUND = 511;
  localparam int VOLT_FULL  = 1023;
  localparam int VOLT_MAX   = 33;
  localparam int VOLT_W     = 6;

  // item kind codes
  localparam logic MODE_SAMPLE  = 1'b0;
  localparam logic MODE_REFRESH = 1'b1;
  localparam logic KIND_READING = 1'b0;
  localparam logic KIND_DISPLAY = 1'b1;

  typedef struct packed {
    logic                mode;
    logic [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic             result_kind;
    logic [BCD_W-1:0] voltage_bcd;
    logic [SEG_W-1:0] segments;
    logic             high_sel;
  } out_item_t;

  typedef int thr_arr_t [VOLT_MAX+1];

  // sum thresholds: reading >= k exactly when sum >= entry k
  // entry k is ceil((1023k - 511) / 33) scaled by the group size
  function automatic thr_arr_t volt_thresholds(int group);
    thr_arr_t t;
    for (int k = 0; k <= VOLT_MAX; k++) begin
      if (k == 0) begin
        t[k] = 0;
      end else begin
        t[k] = ((k * VOLT_FULL - VOLT_ROUND + VOLT_SCALE - 1) / VOLT_SCALE) * group;
      end
    end
    return t;
  endfunction

  // hex seven-segment patterns, bit0 = segment a
  function automatic logic [SEG_W-1:0] hex_segments(logic [3:0] digit);
    logic [SEG_W-1:0] seg;
    unique case (digit)
      4'h0:    seg = 7'h3F;
      4'h1:    seg = 7'h06;
      4'h2:    seg = 7'h5B;
      4'h3:    seg = 7'h4F;
      4'h4:    seg = 7'h66;
      4'h5:    seg = 7'h6D;
      4'h6:    seg = 7'h7D;
      4'h7:    seg = 7'h07;
      4'h8:    seg = 7'h7F;
      4'h9:    seg = 7'h6F;
      4'hA:    seg = 7'h77;
      4'hB:    seg = 7'h7C;
      4'hC:    seg = 7'h39;
      4'hD:    seg = 7'h5E;
      4'hE:    seg = 7'h79;
      4'hF:    seg = 7'h71;
      default: seg = 7'h00;
    endcase
    return seg;
  endfunction

endpackage

@@ rtl/adc_average_voltmeter_display.sv @@
// adc_average_voltmeter_display: sample averaging, scaling to BCD and display drive
// depends on adcv_pkg for item types, scaling thresholds and the segment table
//
// Usage:
//   in channel (in_valid / in_stall / in_data) carries either a converter sample
//   (mode 0) or a display refresh tick (mode 1). Samples are summed; every
//   GROUP_SIZE-th sample closes the group and yields a reading item with the new
//   two-digit BCD voltage in tenths of a volt (0.0 to 3.3). Each refresh tick
//   yields a display item with the segment pattern of one digit, low digit
//   first, then alternating. Samples that do not close a group yield nothing.
//   out channel (out_valid / out_stall / out_data) carries the result items.
//   Each result is registered in the output register, or in the skid register
//   while out_stall holds it; one item is taken every cycle while in_stall is low.
//   A two-entry output buffer (output register plus skid register) lets input
//   continue while a result waits; in_stall rises only when both are full.
//   Reset clears the sum, sample count, stored reading (0.0) and digit select,
//   and empties the output buffer.

module adc_average_voltmeter_display
  import adcv_pkg::*;
#(
  parameter int GROUP_SIZE = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int CNT_W = $clog2(GROUP_SIZE);
  localparam int SUM_W = SAMPLE_W + $clog2(GROUP_SIZE);
  localparam thr_arr_t THR = volt_thresholds(GROUP_SIZE);

  // accumulation and display state
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [BCD_W-1:0] volt_bcd_r, volt_bcd_nxt;
  logic             high_next_r, high_next_nxt;

  // output buffer
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_item_t skid_data_r, skid_data_nxt;

  logic             accept;
  logic             group_done;
  logic [SUM_W-1:0] sum_full;
  logic [VOLT_W-1:0] volt;
  logic [1:0]       tens;
  logic [3:0]       units;
  logic [3:0]       digit;
  logic             res_valid;
  out_item_t        res;

  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !skid_valid_r;

  assign sum_full   = sum_r + SUM_W'(in_data.sample);
  assign group_done = (count_r == CNT_W'(GROUP_SIZE - 1));

  // reading from the group sum, by compare against scaled thresholds
  always_comb begin
    volt = '0;
    for (int k = 1; k <= VOLT_MAX; k++) begin
      if (sum_full >= SUM_W'(THR[k])) begin
        volt = VOLT_W'(k);
      end
    end
  end

  // binary reading to two bcd digits
  always_comb begin
    priority if (volt >= 6'd30) begin
      tens  = 2'd3;
      units = 4'(volt - 6'd30);
    end else if (volt >= 6'd20) begin
      tens  = 2'd2;
      units = 4'(volt - 6'd20);
    end else if (volt >= 6'd10) begin
      tens  = 2'd1;
      units = 4'(volt - 6'd10);
    end else begin
      tens  = 2'd0;
      units = 4'(volt);
    end
  end

  // digit shown on this refresh tick
  assign digit = high_next_r ? {2'b00, volt_bcd_r[5:4]} : volt_bcd_r[3:0];

  // result item and state update for the accepted item
  always_comb begin
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    volt_bcd_nxt  = volt_bcd_r;
    high_next_nxt = high_next_r;
    res_valid     = 1'b0;
    res           = '0;
    if (accept) begin
      unique case (in_data.mode)
        MODE_SAMPLE: begin
          if (group_done) begin
            sum_nxt         = '0;
            count_nxt       = '0;
            volt_bcd_nxt    = {tens, units};
            res_valid       = 1'b1;
            res.result_kind = KIND_READING;
            res.voltage_bcd = {tens, units};
          end else begin
            sum_nxt   = sum_full;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        MODE_REFRESH: begin
          high_next_nxt   = !high_next_r;
          res_valid       = 1'b1;
          res.result_kind = KIND_DISPLAY;
          res.voltage_bcd = volt_bcd_r;
          res.segments    = hex_segments(digit);
          res.high_sel    = high_next_r;
        end
        default: ;
      endcase
    end
  end

  // output register with skid stage
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = res_valid;
        out_data_nxt  = res;
      end
    end else if (res_valid) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r        <= '0;
      count_r      <= '0;
      volt_bcd_r   <= '0;
      high_next_r  <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      sum_r        <= sum_nxt;
      count_r      <= count_nxt;
      volt_bcd_r   <= volt_bcd_nxt;
      high_next_r  <= high_next_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ tb/adc_average_voltmeter_display_tb.sv @@
// adc_average_voltmeter_display_tb: self-checking bench for the averaging voltmeter
// predicts readings and display items in a scoreboard class and checks every output item
// depends on adcv_pkg and adc_average_voltmeter_display

module adc_average_voltmeter_display_tb
  import adcv_pkg::*;
();

  localparam int GROUP_SIZE   = 8;
  localparam int HOLD_CYCLES  = 80;
  localparam int STUCK_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 10;

  // predicts the voltage reading and display items and holds them in order
  class volt_scoreboard;
    out_item_t        expected_q[$];
    int unsigned      error_count;
    int               group_len;
    int               sum_acc;
    int               sample_count;
    logic [7:0]       volt_bcd;
    logic             high_next;
    logic [SEG_W-1:0] seg_lut [16];

    function new(int group);
      group_len    = group;
      error_count  = 0;
      sum_acc      = 0;
      sample_count = 0;
      volt_bcd     = 8'h00;
      high_next    = 1'b0;
      seg_lut      = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
                       7'h7F, 7'h6F, 7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71};
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // update the predicted state with one accepted input item
    function void note_item(in_item_t it);
      out_item_t  want;
      int         avg;
      int         tenths;
      logic [3:0] digit;
      if (it.mode == MODE_SAMPLE) begin
        sum_acc += int'(it.sample);
        sample_count++;
        if (sample_count == group_len) begin
          avg    = sum_acc / group_len;
          tenths = (avg * VOLT_SCALE + VOLT_ROUND) / VOLT_FULL;
          volt_bcd[7:4] = 4'(tenths / 10);
          volt_bcd[3:0] = 4'(tenths % 10);
          sum_acc      = 0;
          sample_count = 0;
          want.result_kind = KIND_READING;
          want.voltage_bcd = volt_bcd[5:0];
          want.segments    = '0;
          want.high_sel    = 1'b0;
          expected_q.push_back(want);
        end
      end else begin
        digit = high_next ? volt_bcd[7:4] : volt_bcd[3:0];
        want.result_kind = KIND_DISPLAY;
        want.voltage_bcd = volt_bcd[5:0];
        want.segments    = seg_lut[digit];
        want.high_sel    = high_next;
        expected_q.push_back(want);
        high_next = ~high_next;
      end
    endfunction

    // compare one accepted output item against the oldest prediction
    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected output item %h", got);
        error_count++;
        return;
      end
      want = expected_q.pop_front();
      if (got.result_kind !== want.result_kind) begin
        $error("result_kind: expected %0d, got %0d", want.result_kind, got.result_kind);
        error_count++;
      end
      if (got.voltage_bcd !== want.voltage_bcd) begin
        $error("voltage_bcd: expected %h, got %h", want.voltage_bcd, got.voltage_bcd);
        error_count++;
      end
      if (got.segments !== want.segments) begin
        $error("segments: expected %h, got %h", want.segments, got.segments);
        error_count++;
      end
      if (got.high_sel !== want.high_sel) begin
        $error("high_sel: expected %0d, got %0d", want.high_sel, got.high_sel);
        error_count++;
      end
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  volt_scoreboard sb;
  bit             tx_idle_on   = 1'b1;
  bit             rx_idle_on   = 1'b1;
  bit             hold_req     = 1'b0;
  int             items_sent   = 0;
  int             stuck_cycles = 0;

  adc_average_voltmeter_display #(
    .GROUP_SIZE(GROUP_SIZE)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // monitor both channels and watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        sb.check_result(out_data);
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        sb.note_item(in_data);
      end
      if ((out_valid === 1'b1 && out_stall === 1'b0) ||
          (in_valid === 1'b1 && in_stall === 1'b0)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic in_item_t make_item(logic mode, int value);
    in_item_t it;
    it.mode   = mode;
    it.sample = value[SAMPLE_W-1:0];
    return it;
  endfunction

  // offer one item until accepted, then maybe leave a gap
  task automatic send_item(in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    items_sent++;
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // one full group of samples with refresh ticks sprinkled in
  task automatic send_group();
    int style;
    int level;
    int center;
    int val;
    style  = $urandom_range(0, 3);
    center = $urandom_range(0, 1023);
    level  = $urandom_range(1, VOLT_MAX);
    // average just at or below the point where the reading steps up
    level  = (level * VOLT_FULL - VOLT_ROUND + VOLT_SCALE - 1) / VOLT_SCALE
             - int'($urandom_range(0, 1));
    for (int i = 0; i < GROUP_SIZE; i++) begin
      case (style)
        0:       val = $urandom_range(0, 1023);
        1:       val = level;
        2:       val = ($urandom_range(0, 1) != 0) ? 1023 : 0;
        default: begin
          val = center + int'($urandom_range(0, 16)) - 8;
          if (val < 0) val = 0;
          if (val > 1023) val = 1023;
        end
      endcase
      send_item(make_item(MODE_SAMPLE, val));
      if ($urandom_range(0, 3) == 0) begin
        send_item(make_item(MODE_REFRESH, $urandom_range(0, 1023)));
      end
    end
  endtask

  // mostly whole groups, some tick bursts and stray samples that shift alignment
  task automatic run_random(int n);
    int target;
    int pick;
    target = items_sent + n;
    while (items_sent < target) begin
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        send_group();
      end else if (pick <= 7) begin
        repeat ($urandom_range(1, 4)) send_item(make_item(MODE_REFRESH, $urandom_range(0, 1023)));
      end else begin
        repeat ($urandom_range(1, 5)) send_item(make_item(MODE_SAMPLE, $urandom_range(0, 1023)));
      end
    end
  endtask

  // stimulus
  initial begin
    sb = new(GROUP_SIZE);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // ticks on the reset reading, low digit then high digit
    send_item(make_item(MODE_REFRESH, 0));
    send_item(make_item(MODE_REFRESH, 1023));
    // full-scale group with a tick in the middle: reading 3.3
    repeat (4) send_item(make_item(MODE_SAMPLE, 1023));
    send_item(make_item(MODE_REFRESH, 512));
    repeat (4) send_item(make_item(MODE_SAMPLE, 1023));
    send_item(make_item(MODE_REFRESH, 0));
    send_item(make_item(MODE_REFRESH, 1023));
    // all-zero group: reading 0.0
    repeat (8) send_item(make_item(MODE_SAMPLE, 0));
    send_item(make_item(MODE_REFRESH, 341));

    run_random(900);

    // long receiver hold-off while the sender keeps offering items
    tx_idle_on = 1'b0;
    hold_req   = 1'b1;
    repeat (30) send_item(make_item(MODE_REFRESH, $urandom_range(0, 1023)));
    while (hold_req) @(posedge clk);

    // sender pause until every result is out
    in_valid <= 1'b0;
    wait_drained();
    tx_idle_on = 1'b1;

    run_random(380);

    // closing stretch at full rate
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_random(150);

    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
